### rtl/core/rc5e_pkg.sv
// Shared constants, types and helpers for the RC5 infrared frame encoder.
// No dependencies; every other file of the block uses this package.
package rc5e_pkg;

  // Frame length in bits and field widths
  localparam int FRAME_BITS = 13;
  localparam int CODE_W     = 13;
  localparam int GAP_W      = 8;
  localparam int BITS_W     = $clog2(FRAME_BITS + 1);

  // Code values and bit positions
  localparam int                TOGGLE_POS   = 11;
  localparam logic [CODE_W-1:0] CODE_INVALID = 13'h1000;
  localparam logic [GAP_W-1:0]  GAP_RESET    = 8'd100;

  // Command codes carried by an input word
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SEND   = 2'd1,
    CMD_REPEAT = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  // One result word
  typedef struct packed {
    logic carrier_on;
    logic busy_res;
  } result_t;

  // A code starts a frame only if it is neither zero nor the invalid pattern
  function automatic logic code_valid(input logic [CODE_W-1:0] c);
    return (c != '0) && (c != CODE_INVALID);
  endfunction

  // Fit a stored code into the frame shift register, zero-extended or truncated
  function automatic logic [FRAME_BITS-1:0] load_word(input logic [CODE_W-1:0] c);
    logic [FRAME_BITS+CODE_W-1:0] ext;
    ext = {{FRAME_BITS{1'b0}}, c};
    return ext[FRAME_BITS-1:0];
  endfunction

endpackage

### rtl/core/rc5e_ifs.sv
// Valid/ready channel interfaces of the RC5 frame encoder: command words in,
// result words out, and the gap length write channel. Depends on rc5e_pkg.

interface rc5e_item_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [rc5e_pkg::CODE_W-1:0] code;

  modport source (output valid, output cmd, output code, input ready);
  modport sink   (input valid, input cmd, input code, output ready);
endinterface

interface rc5e_result_if;
  logic valid;
  logic ready;
  logic carrier_on;
  logic busy_res;

  modport source (output valid, output carrier_on, output busy_res, input ready);
  modport sink   (input valid, input carrier_on, input busy_res, output ready);
endinterface

interface rc5e_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rc5e_pkg::GAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rc5e_frame_seq.sv
// Frame sequencer: phase machine, shift register, toggle and gap counting.
// Advances one step per accepted command word. Depends on rc5e_pkg.
module rc5e_frame_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [1:0]                  cmd,
  input  logic [rc5e_pkg::CODE_W-1:0] code,
  input  logic [rc5e_pkg::GAP_W-1:0]  gap_ticks,
  output rc5e_pkg::result_t           result
);
  import rc5e_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START_LO = 3'd1,
    PH_START_HI = 3'd2,
    PH_BIT_A    = 3'd3,
    PH_BIT_B    = 3'd4,
    PH_GAP      = 3'd5
  } phase_t;

  phase_t                phase, phase_next;
  logic [FRAME_BITS-1:0] shift_word, shift_word_next;
  logic [CODE_W-1:0]     active_code, active_code_next;
  logic [BITS_W-1:0]     bits_sent, bits_sent_next;
  logic [GAP_W-1:0]      gap_count, gap_count_next;
  logic                  toggle_flag, toggle_flag_next;
  logic                  carrier_level, carrier_level_next;
  logic [BITS_W-1:0]     bits_inc;
  logic [GAP_W-1:0]      gap_inc;

  assign bits_inc = bits_sent + 1'b1;
  assign gap_inc  = gap_count + 1'b1;

  // Work out the state after this command word
  always_comb begin
    phase_next         = phase;
    shift_word_next    = shift_word;
    active_code_next   = active_code;
    bits_sent_next     = bits_sent;
    gap_count_next     = gap_count;
    toggle_flag_next   = toggle_flag;
    carrier_level_next = carrier_level;

    case (cmd_t'(cmd))
      CMD_TICK: begin
        unique case (phase)
          PH_IDLE: begin
            carrier_level_next = 1'b0;
          end
          PH_START_LO: begin
            carrier_level_next = 1'b0;
            phase_next         = PH_START_HI;
          end
          PH_START_HI: begin
            carrier_level_next = 1'b1;
            phase_next         = PH_BIT_A;
          end
          PH_BIT_A: begin
            carrier_level_next = ~shift_word[FRAME_BITS-1];
            shift_word_next    = shift_word << 1;
            phase_next         = PH_BIT_B;
          end
          PH_BIT_B: begin
            carrier_level_next = ~carrier_level;
            bits_sent_next     = bits_inc;
            phase_next         = (bits_inc >= BITS_W'(FRAME_BITS)) ? PH_GAP : PH_BIT_A;
          end
          PH_GAP: begin
            carrier_level_next = 1'b0;
            gap_count_next     = gap_inc;
            if (gap_inc >= gap_ticks) begin
              bits_sent_next = '0;
              gap_count_next = '0;
              phase_next     = PH_IDLE;
            end
          end
          default: begin
            carrier_level_next = 1'b0;
            phase_next         = PH_IDLE;
          end
        endcase
      end
      CMD_SEND: begin
        // Store the code; force the toggle bit only for a usable code
        active_code_next = code;
        if (code_valid(code)) begin
          active_code_next[TOGGLE_POS] = ~toggle_flag;
          if (code_valid(active_code_next) && phase == PH_IDLE) begin
            shift_word_next = load_word(active_code_next);
            phase_next      = PH_START_LO;
          end
        end
      end
      CMD_REPEAT: begin
        if (code_valid(active_code) && phase == PH_IDLE) begin
          shift_word_next = load_word(active_code);
          phase_next      = PH_START_LO;
        end
      end
      default: begin
        toggle_flag_next = ~toggle_flag;
        active_code_next = '0;
      end
    endcase
  end

  assign result.carrier_on = carrier_level_next;
  assign result.busy_res   = (phase_next != PH_IDLE);

  // Hold state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      shift_word    <= '0;
      active_code   <= '0;
      bits_sent     <= '0;
      gap_count     <= '0;
      toggle_flag   <= 1'b0;
      carrier_level <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      shift_word    <= shift_word_next;
      active_code   <= active_code_next;
      bits_sent     <= bits_sent_next;
      gap_count     <= gap_count_next;
      toggle_flag   <= toggle_flag_next;
      carrier_level <= carrier_level_next;
    end
  end

endmodule

### rtl/core/rc5_ir_frame_encoder_core.sv
// Top level of the RC5 infrared frame encoder: gap register, frame sequencer
// and output skid stage. Depends on rc5e_pkg, rc5e_ifs and rc5e_frame_seq.
//
// Usage:
//   item   - command words (cmd, code): tick, send, repeat, stop. Each word
//            gives exactly one result word.
//   result - carrier_on (carrier enable for this half-bit) and busy_res
//            (frame or gap in progress after the command).
//   cfg    - write of gap_ticks, the silent ticks after a frame; always ready.
//            Write it only while no result is outstanding.
// Output: a result word is registered in the output register or the skid register.
// Throughput: one word per cycle while results are taken; a whole sequencer step is a
//   single pass of logic between the command handshake and the result register.
// Reset: phase idle, stored code and toggle cleared, gap_ticks back to 100,
//   no result pending.
// Stall: with the result held, one more word is taken into a skid register;
//   item.ready then drops until the receiver takes the held word.
module rc5_ir_frame_encoder_core (
  input  logic           clk,
  input  logic           rst,
  rc5e_item_if.sink      item,
  rc5e_result_if.source  result,
  rc5e_cfg_if.sink       cfg
);
  import rc5e_pkg::*;

  logic [GAP_W-1:0] gap_ticks;
  logic             accept;
  logic             pop;
  result_t          step_res;
  result_t          out_res, skid_res;
  logic             out_valid, skid_valid;

  // Hold the gap length register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks <= GAP_RESET;
    end else if (cfg.valid) begin
      gap_ticks <= cfg.data;
    end
  end

  assign item.ready = ~skid_valid;
  assign accept     = item.valid & item.ready;
  assign pop        = out_valid & result.ready;

  rc5e_frame_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .cmd       (item.cmd),
    .code      (item.code),
    .gap_ticks (gap_ticks),
    .result    (step_res)
  );

  // Output register with skid: refill from skid first, else from the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_res <= skid_valid ? skid_res : step_res;
    end
    if (out_valid && !pop && accept) begin
      skid_res <= step_res;
    end
  end

  assign result.valid      = out_valid;
  assign result.carrier_on = out_res.carrier_on;
  assign result.busy_res   = out_res.busy_res;

  // A filled skid always sits behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word present without output word");

  // A word accepted during a stall lands in the skid register
  a_stall_capture: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready && accept) |=> skid_valid)
    else $error("word accepted during stall was not captured");

  // Once the skid drains, the output stays valid with the skid word
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && result.ready) |=> (out_valid && !skid_valid))
    else $error("skid word lost on drain");

endmodule

### tb/sv/rc5e_frame_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the RC5 frame encoder: mirrors the half-bit sequencer and checks every
// result word. Watches the item, result and gap channels; depends on rc5e_pkg.
module rc5e_frame_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic                        item_ready,
  input  logic [1:0]                  item_cmd,
  input  logic [rc5e_pkg::CODE_W-1:0] item_code,
  input  logic                        res_valid,
  input  logic                        res_ready,
  input  logic                        res_carrier,
  input  logic                        res_busy,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [rc5e_pkg::GAP_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending
);
  import rc5e_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START_LO,
    SEQ_START_HI,
    SEQ_BIT_FIRST,
    SEQ_BIT_SECOND,
    SEQ_GAP
  } seq_phase_t;

  // Mirror of the encoder state
  seq_phase_t            seq_phase;
  logic [FRAME_BITS-1:0] frame_shift;
  logic [CODE_W-1:0]     stored_code;
  logic [BITS_W-1:0]     half_bits_done;
  logic [GAP_W-1:0]      gap_elapsed;
  logic [GAP_W-1:0]      gap_len;
  logic                  toggle_odd;
  logic                  carrier_level;

  result_t     line_levels_q[$];
  int          mismatches;
  int unsigned word_idx;

  initial begin
    mismatches = 0;
    word_idx   = 0;
  end

  // Print one line per mismatch (the first hundred) and count all of them
  task automatic report_mismatch(input string field, input logic got, input logic want);
    if (mismatches < 100)
      $display("mismatch at result word %0d: %s got %b, want %b", word_idx, field, got, want);
    mismatches++;
  endtask

  // Load the stored code into the shift register when idle and the code can go out
  function automatic void launch_frame();
    if (stored_code != '0 && stored_code != CODE_INVALID && seq_phase == SEQ_IDLE) begin
      frame_shift = FRAME_BITS'(stored_code);
      seq_phase   = SEQ_START_LO;
    end
  endfunction

  // Apply one command word and return the line levels it leaves behind
  function automatic result_t encode_step(input cmd_t op, input logic [CODE_W-1:0] cd);
    result_t levels;
    case (op)
      CMD_TICK: begin
        case (seq_phase)
          SEQ_START_LO: begin
            carrier_level = 1'b0;
            seq_phase     = SEQ_START_HI;
          end
          SEQ_START_HI: begin
            carrier_level = 1'b1;
            seq_phase     = SEQ_BIT_FIRST;
          end
          SEQ_BIT_FIRST: begin
            // Manchester: a one starts low
            carrier_level = ~frame_shift[FRAME_BITS-1];
            frame_shift   = frame_shift << 1;
            seq_phase     = SEQ_BIT_SECOND;
          end
          SEQ_BIT_SECOND: begin
            carrier_level  = ~carrier_level;
            half_bits_done = half_bits_done + 1'b1;
            seq_phase      = (half_bits_done >= FRAME_BITS) ? SEQ_GAP : SEQ_BIT_FIRST;
          end
          SEQ_GAP: begin
            carrier_level = 1'b0;
            gap_elapsed   = gap_elapsed + 1'b1;
            if (gap_elapsed >= gap_len) begin
              half_bits_done = '0;
              gap_elapsed    = '0;
              seq_phase      = SEQ_IDLE;
            end
          end
          default: begin
            carrier_level = 1'b0;
            seq_phase     = SEQ_IDLE;
          end
        endcase
      end
      CMD_SEND: begin
        stored_code = cd;
        if (cd != '0 && cd != CODE_INVALID) begin
          // Toggle bit follows the parity of the stop count
          stored_code[TOGGLE_POS] = ~toggle_odd;
          launch_frame();
        end
      end
      CMD_REPEAT: launch_frame();
      default: begin
        toggle_odd  = ~toggle_odd;
        stored_code = '0;
      end
    endcase
    levels.carrier_on = carrier_level;
    levels.busy_res   = (seq_phase != SEQ_IDLE);
    return levels;
  endfunction

  // Check result words, predict from command words, then track the gap register
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      seq_phase      = SEQ_IDLE;
      frame_shift    = '0;
      stored_code    = '0;
      half_bits_done = '0;
      gap_elapsed    = '0;
      gap_len        = GAP_RESET;
      toggle_odd     = 1'b0;
      carrier_level  = 1'b0;
      line_levels_q.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (line_levels_q.size() == 0) begin
          report_mismatch("unexpected word, busy_res", res_busy, 1'bx);
        end else begin
          want = line_levels_q.pop_front();
          if (res_carrier !== want.carrier_on)
            report_mismatch("carrier_on", res_carrier, want.carrier_on);
          if (res_busy !== want.busy_res)
            report_mismatch("busy_res", res_busy, want.busy_res);
        end
        word_idx++;
      end
      if (item_valid && item_ready)
        line_levels_q.push_back(encode_step(cmd_t'(item_cmd), item_code));
      if (cfg_valid && cfg_ready)
        gap_len = cfg_data;
    end
    pending    <= line_levels_q.size();
    fail_count <= mismatches;
  end

endmodule

### tb/sv/tb_rc5_ir_frame_encoder_core.sv
`timescale 1ns / 100ps
// Top of the RC5 frame encoder testbench: clock, reset, command and gap stimulus, result
// back-pressure and the verdict. Depends on rc5e_pkg, rc5e_ifs and rc5e_frame_checker.
module tb_rc5_ir_frame_encoder_core;
  import rc5e_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 5;

  logic clk;
  logic rst;
  bit   quiet;
  bit   hold_arm;
  bit   hold_taken;
  int   hold_left;
  int   fail_count;
  int   pending;

  rc5e_item_if   item_if ();
  rc5e_result_if result_if ();
  rc5e_cfg_if    cfg_if ();

  rc5_ir_frame_encoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  rc5e_frame_checker chk (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_if.valid),
    .item_ready  (item_if.ready),
    .item_cmd    (item_if.cmd),
    .item_code   (item_if.code),
    .res_valid   (result_if.valid),
    .res_ready   (result_if.ready),
    .res_carrier (result_if.carrier_on),
    .res_busy    (result_if.busy_res),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_data    (cfg_if.data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once armed
  always @(negedge clk) begin
    if (hold_arm && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < 12) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Offer one command word, idling first now and then, and hold it until taken
  task automatic offer_command(input cmd_t op, input logic [CODE_W-1:0] cd);
    int idle;
    if (!quiet && $urandom_range(99) < 12) begin
      idle = $urandom_range(1, 2);
      @(negedge clk);
      item_if.valid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    item_if.valid <= 1'b1;
    item_if.cmd   <= op;
    item_if.code  <= cd;
    do @(posedge clk); while (!(item_if.valid && item_if.ready));
  endtask

  // Drop valid and hold until every predicted word has come back
  task automatic wait_drained();
    @(negedge clk);
    item_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_gap_ticks(input logic [GAP_W-1:0] ticks);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= ticks;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly a random code, sometimes one of the codes with special handling
  function automatic logic [CODE_W-1:0] pick_code();
    logic [CODE_W-1:0] picks[5];
    picks = '{13'h0000, 13'h1000, 13'h0800, 13'h1800, 13'h1FFF};
    if ($urandom_range(3) == 0)
      return picks[$urandom_range(4)];
    return CODE_W'($urandom_range(0, 8191));
  endfunction

  initial begin
    logic [GAP_W-1:0] gap_plan[PHASES];
    int               words_plan[PHASES];
    int               pick;

    item_if.valid = 1'b0;
    item_if.cmd   = CMD_TICK;
    item_if.code  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    quiet         = 1'b0;
    hold_arm      = 1'b0;
    rst           = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset gap length
    offer_command(CMD_TICK, 13'h1FFF);        // tick while idle
    offer_command(CMD_SEND, 13'h0000);        // zero code is stored, no frame
    offer_command(CMD_REPEAT, 13'h0AAA);      // nothing valid to repeat
    offer_command(CMD_SEND, CODE_INVALID);    // invalid pattern is stored, no frame
    offer_command(CMD_REPEAT, 13'h0000);
    offer_command(CMD_STOP, 13'h1555);        // toggle count goes odd
    offer_command(CMD_SEND, 13'h0800);        // clears to zero with toggle odd
    offer_command(CMD_REPEAT, 13'h1FFF);
    offer_command(CMD_SEND, 13'h1FFF);        // starts a frame
    offer_command(CMD_SEND, 13'h0001);        // busy: stored only
    offer_command(CMD_REPEAT, 13'h0000);      // busy: ignored
    offer_command(CMD_STOP, 13'h1FFF);        // frame in progress keeps going
    repeat (12) offer_command(CMD_TICK, CODE_W'($urandom_range(0, 8191)));
    wait_drained();

    // Random phases, each at its own gap length
    gap_plan   = '{8'd1, 8'd9, 8'd255, GAP_W'($urandom_range(10, 60)), 8'd2};
    words_plan = '{260, 260, 400, 260, 250};
    for (int p = 0; p < PHASES; p++) begin
      load_gap_ticks(gap_plan[p]);
      quiet = (p == 1);
      if (p == 3)
        hold_arm = 1'b1;
      for (int n = 0; n < words_plan[p]; n++) begin
        pick = $urandom_range(99);
        if (pick < 80)
          offer_command(CMD_TICK, CODE_W'($urandom_range(0, 8191)));
        else if (pick < 89)
          offer_command(CMD_SEND, pick_code());
        else if (pick < 95)
          offer_command(CMD_REPEAT, CODE_W'($urandom_range(0, 8191)));
        else
          offer_command(CMD_STOP, CODE_W'($urandom_range(0, 8191)));
      end
      wait_drained();
    end

    quiet = 1'b0;
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
